// ===== hdl/adcbcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbcs_pkg
// Shared constants, record types and helpers for the ADC channel statistics.
// ----------------------------------------------------------------------------
package adcbcs_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W     = 4;   // channel field
  localparam int SMP_W    = 16;  // sample and result fields
  localparam int ACC_W    = 24;  // difference and sample sums
  localparam int CNT_W    = 8;   // per-channel sample count
  localparam int BS_W     = 8;   // block_size register

  localparam logic [BS_W-1:0]  BS_RESET = BS_W'(16);
  localparam logic [SMP_W-1:0] SAT16    = {SMP_W{1'b1}};

  // One channel record as held in the record RAM
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SMP_W-1:0] prev;
    logic [ACC_W-1:0] diff;
    logic [SMP_W-1:0] high;
    logic [SMP_W-1:0] low;
    logic [ACC_W-1:0] sum;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Block-close status from the update logic
  typedef struct packed {
    logic             closes;
    logic [SMP_W-1:0] diff_sat;
    logic [SMP_W-1:0] span;
    logic [ACC_W-1:0] sum;
  } close_t;

  function automatic logic in_range(input logic [CH_W-1:0] ch);
    return 32'(ch) < CHANNELS;
  endfunction

  function automatic logic [CH_AW-1:0] to_index(input logic [CH_W-1:0] ch);
    logic [CH_AW+CH_W-1:0] wide;
    wide = {{CH_AW{1'b0}}, ch};
    return wide[CH_AW-1:0];
  endfunction

  function automatic logic [CH_W-1:0] to_channel(input logic [CH_AW-1:0] idx);
    logic [CH_AW+CH_W-1:0] wide;
    wide = {{CH_W{1'b0}}, idx};
    return wide[CH_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/adcbcs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbcs_if
// Valid/ready channels for samples in and block statistics out.
// ----------------------------------------------------------------------------
interface adcbcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [adcbcs_pkg::CH_W-1:0]    channel;
  logic [adcbcs_pkg::SMP_W-1:0]   sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface adcbcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [adcbcs_pkg::CH_W-1:0]    out_channel;
  logic [adcbcs_pkg::SMP_W-1:0]   diff_sum;
  logic [adcbcs_pkg::SMP_W-1:0]   peak_to_peak;
  logic [adcbcs_pkg::SMP_W-1:0]   mean;

  modport source (output valid, output out_channel, output diff_sum,
                  output peak_to_peak, output mean, input ready);
  modport sink   (input valid, input out_channel, input diff_sum,
                  input peak_to_peak, input mean, output ready);
endinterface
`default_nettype wire

// ===== hdl/adc_block_channel_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_block_channel_stats
// Per-channel ADC block statistics: difference sum, peak-to-peak and mean.
// ----------------------------------------------------------------------------
//  channel  direction  handshake     payload
//  in_beat  in         valid/ready   channel, sample
//  out_beat out        valid/ready   out_channel, diff_sum, peak_to_peak, mean
//  cfg      in         cfg_we        cfg_wdata (block_size)
//
//  A sample that does not close a block is accepted with a record RAM read,
//  then updated and written back. A closing sample also waits on the
//  24-step serial divider that forms the mean.
//  Reset clears the per-channel valid bits (counts read as zero); no clearing
//  pass. A pending result waiting on out_beat holds only the next closing beat.
// ----------------------------------------------------------------------------
module adc_block_channel_stats (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  adcbcs_in_if.sink                          in_beat,
  adcbcs_out_if.source                       out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [adcbcs_pkg::BS_W-1:0]   cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [adcbcs_pkg::BS_W-1:0]      bs_r;
  logic [adcbcs_pkg::BS_W-1:0]      bs_eff;
  logic [adcbcs_pkg::CH_AW-1:0]     ch_r;
  logic [adcbcs_pkg::SMP_W-1:0]     smp_r;
  logic [adcbcs_pkg::CHANNELS-1:0]  vld_r;
  logic [adcbcs_pkg::SMP_W-1:0]     diff_r;
  logic [adcbcs_pkg::SMP_W-1:0]     span_r;

  logic                             out_valid_r, out_valid_nxt;
  logic [adcbcs_pkg::CH_W-1:0]      out_ch_r;
  logic [adcbcs_pkg::SMP_W-1:0]     out_diff_r;
  logic [adcbcs_pkg::SMP_W-1:0]     out_span_r;
  logic [adcbcs_pkg::SMP_W-1:0]     out_mean_r;

  logic                             in_fire;
  logic                             ram_we;
  logic [adcbcs_pkg::REC_W-1:0]     ram_rdata;
  adcbcs_pkg::rec_t                 cur_rec;
  adcbcs_pkg::rec_t                 wr_rec;
  adcbcs_pkg::close_t               cls;
  logic                             div_start;
  logic                             div_done;
  logic [adcbcs_pkg::SMP_W-1:0]     div_quot;
  logic                             load_out;

  assign in_beat.ready = (state_r == S_IDLE);
  assign in_fire       = in_beat.valid && in_beat.ready;
  assign bs_eff        = (bs_r == '0) ? adcbcs_pkg::BS_W'(1) : bs_r;

  // never-written channel reads as an empty record
  assign cur_rec   = vld_r[ch_r] ? adcbcs_pkg::rec_t'(ram_rdata) : '0;
  assign ram_we    = (state_r == S_READ);
  assign div_start = (state_r == S_READ) && cls.closes;
  assign load_out  = (state_r == S_DIV) && div_done && (!out_valid_r || out_beat.ready);

  adcbcs_ram #(
    .WIDTH (adcbcs_pkg::REC_W),
    .DEPTH (adcbcs_pkg::CHANNELS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_r),
    .wdata (wr_rec),
    .re    (in_fire),
    .raddr (adcbcs_pkg::to_index(in_beat.channel)),
    .rdata (ram_rdata)
  );

  adcbcs_update u_update (
    .cur    (cur_rec),
    .sample (smp_r),
    .bs     (bs_eff),
    .wr_rec (wr_rec),
    .cls    (cls)
  );

  adcbcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cls.sum),
    .divisor  (bs_eff),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && adcbcs_pkg::in_range(in_beat.channel)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = cls.closes ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bs_r        <= adcbcs_pkg::BS_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bs_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[ch_r] <= 1'b1;
      end
    end

    if (in_fire) begin
      ch_r  <= adcbcs_pkg::to_index(in_beat.channel);
      smp_r <= in_beat.sample;
    end
    if (div_start) begin
      diff_r <= cls.diff_sat;
      span_r <= cls.span;
    end
    if (load_out) begin
      out_ch_r   <= adcbcs_pkg::to_channel(ch_r);
      out_diff_r <= diff_r;
      out_span_r <= span_r;
      out_mean_r <= div_quot;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.out_channel  = out_ch_r;
  assign out_beat.diff_sum     = out_diff_r;
  assign out_beat.peak_to_peak = out_span_r;
  assign out_beat.mean         = out_mean_r;

`ifndef SYNTH
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_IDLE || state_r == S_DIV))
    else $error("record read held for more than one cycle");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done && !out_valid_r) |=> out_valid_r)
    else $error("finished mean not moved to output register");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DIV))
    else $error("result raised outside divide phase");

  a_ignored_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !adcbcs_pkg::in_range(in_beat.channel)) |=> (state_r == S_IDLE))
    else $error("out-of-range channel started an update");
`endif

endmodule
`default_nettype wire

// ===== hdl/adcbcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module adcbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/adcbcs_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbcs_update
// Read-modify-write step: folds one sample into a channel record.
// ----------------------------------------------------------------------------
module adcbcs_update (
  input  wire adcbcs_pkg::rec_t                cur,
  input  wire logic [adcbcs_pkg::SMP_W-1:0]    sample,
  input  wire logic [adcbcs_pkg::BS_W-1:0]     bs,
  output adcbcs_pkg::rec_t                     wr_rec,
  output adcbcs_pkg::close_t                   cls
);

  adcbcs_pkg::rec_t              upd;
  logic                          first;
  logic [adcbcs_pkg::SMP_W-1:0]  delta;

  always_comb begin
    first = (cur.count == '0);
    delta = (sample >= cur.prev) ? (sample - cur.prev) : (cur.prev - sample);

    upd.prev  = sample;
    upd.count = cur.count + adcbcs_pkg::CNT_W'(1);
    if (first) begin
      // first beat of a block seeds everything
      upd.diff = '0;
      upd.high = sample;
      upd.low  = sample;
      upd.sum  = adcbcs_pkg::ACC_W'(sample);
    end else begin
      upd.diff = cur.diff + adcbcs_pkg::ACC_W'(delta);
      upd.high = (sample > cur.high) ? sample : cur.high;
      upd.low  = (sample < cur.low)  ? sample : cur.low;
      upd.sum  = cur.sum + adcbcs_pkg::ACC_W'(sample);
    end

    cls.closes   = (upd.count >= bs);
    cls.diff_sat = (|upd.diff[adcbcs_pkg::ACC_W-1:adcbcs_pkg::SMP_W])
                   ? adcbcs_pkg::SAT16 : upd.diff[adcbcs_pkg::SMP_W-1:0];
    cls.span     = upd.high - upd.low;
    cls.sum      = upd.sum;

    wr_rec = cls.closes ? '0 : upd;
  end

endmodule
`default_nettype wire

// ===== hdl/adcbcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbcs_div
// Restoring serial divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module adcbcs_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [adcbcs_pkg::ACC_W-1:0]  dividend,
  input  wire logic [adcbcs_pkg::BS_W-1:0]   divisor,
  output logic                               done,
  output logic [adcbcs_pkg::SMP_W-1:0]       quotient
);

  localparam int STEPS = adcbcs_pkg::ACC_W;
  localparam int SC_W  = $clog2(STEPS + 1);
  localparam int DW    = adcbcs_pkg::BS_W;
  localparam int AW    = adcbcs_pkg::ACC_W;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SC_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dsr_r, dsr_nxt;
  logic [AW-1:0]   dvd_r, dvd_nxt;
  logic [AW-1:0]   quo_r, quo_nxt;
  logic [DW:0]     shifted;
  logic [DW:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r, dvd_r[AW-1]};
    trial    = shifted - {1'b0, dsr_r};

    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = SC_W'(STEPS);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits DW bits
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[AW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[AW-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[AW-2:0], 1'b0};
      cnt_nxt = cnt_r - SC_W'(1);
      if (cnt_r == SC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = (|quo_r[AW-1:adcbcs_pkg::SMP_W]) ? adcbcs_pkg::SAT16
                                                     : quo_r[adcbcs_pkg::SMP_W-1:0];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tagged ADC samples into adc_block_channel_stats under several block
// sizes and idling patterns. A per-channel record kept here predicts every
// block result. Each result beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHANNELS = adcbcs_pkg::CHANNELS;
  localparam int CH_W     = adcbcs_pkg::CH_W;
  localparam int SMP_W    = adcbcs_pkg::SMP_W;
  localparam int ACC_W    = adcbcs_pkg::ACC_W;
  localparam int CNT_W    = adcbcs_pkg::CNT_W;
  localparam int BS_W     = adcbcs_pkg::BS_W;
  localparam logic [BS_W-1:0]  BS_RESET = adcbcs_pkg::BS_RESET;
  localparam logic [SMP_W-1:0] SAT16    = adcbcs_pkg::SAT16;

  localparam int SETTLE_CYCLES = 40;       // covers a closing beat
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] diff_sum;
    logic [SMP_W-1:0] peak_to_peak;
    logic [SMP_W-1:0] mean;
  } block_stats_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [BS_W-1:0] cfg_wdata;

  adcbcs_in_if  in_beat_if ();
  adcbcs_out_if out_beat_if ();

  adc_block_channel_stats i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat_if),
    .out_beat (out_beat_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted per-channel records and the block size in force
  logic [BS_W-1:0]  block_size_now;
  logic [CNT_W-1:0] rec_count [CHANNELS];
  logic [SMP_W-1:0] rec_prev  [CHANNELS];
  logic [ACC_W-1:0] rec_diff  [CHANNELS];
  logic [SMP_W-1:0] rec_high  [CHANNELS];
  logic [SMP_W-1:0] rec_low   [CHANNELS];
  logic [ACC_W-1:0] rec_sum   [CHANNELS];

  block_stats_t stats_expected [$];

  int mismatch_count = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_beat_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_beat_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void clear_record(input int idx);
    rec_count[idx] = '0;
    rec_prev[idx]  = '0;
    rec_diff[idx]  = '0;
    rec_high[idx]  = '0;
    rec_low[idx]   = '0;
    rec_sum[idx]   = '0;
  endfunction

  function automatic void predict_sample(input logic [CH_W-1:0] ch,
                                         input logic [SMP_W-1:0] s);
    int idx;
    logic [BS_W-1:0]  bs;
    logic [SMP_W-1:0] step;
    logic [ACC_W-1:0] avg;
    block_stats_t     res;
    idx = int'(ch);
    if (idx >= CHANNELS) return;
    bs = (block_size_now == '0) ? BS_W'(1) : block_size_now;
    if (rec_count[idx] == '0) begin
      rec_diff[idx] = '0;
      rec_high[idx] = s;
      rec_low[idx]  = s;
      rec_sum[idx]  = ACC_W'(s);
    end else begin
      step = (s >= rec_prev[idx]) ? s - rec_prev[idx] : rec_prev[idx] - s;
      rec_diff[idx] = rec_diff[idx] + ACC_W'(step);
      if (s > rec_high[idx]) rec_high[idx] = s;
      if (s < rec_low[idx])  rec_low[idx]  = s;
      rec_sum[idx] = rec_sum[idx] + ACC_W'(s);
    end
    rec_prev[idx]  = s;
    rec_count[idx] = rec_count[idx] + 1'b1;
    if (rec_count[idx] < bs) return;
    avg = rec_sum[idx] / ACC_W'(bs);
    res.channel      = ch;
    res.diff_sum     = (rec_diff[idx] > ACC_W'(SAT16)) ? SAT16 : rec_diff[idx][SMP_W-1:0];
    res.peak_to_peak = rec_high[idx] - rec_low[idx];
    res.mean         = (avg > ACC_W'(SAT16)) ? SAT16 : avg[SMP_W-1:0];
    stats_expected.push_back(res);
    clear_record(idx);
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    block_stats_t want;
    if (rst_n && out_beat_if.valid && out_beat_if.ready) begin
      if (stats_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing expected: channel %0d", out_beat_if.out_channel);
      end else begin
        want = stats_expected.pop_front();
        if (out_beat_if.out_channel !== want.channel)
          note_mismatch("out_channel", 32'(want.channel), 32'(out_beat_if.out_channel));
        if (out_beat_if.diff_sum !== want.diff_sum)
          note_mismatch("diff_sum", 32'(want.diff_sum), 32'(out_beat_if.diff_sum));
        if (out_beat_if.peak_to_peak !== want.peak_to_peak)
          note_mismatch("peak_to_peak", 32'(want.peak_to_peak),
                        32'(out_beat_if.peak_to_peak));
        if (out_beat_if.mean !== want.mean)
          note_mismatch("mean", 32'(want.mean), 32'(out_beat_if.mean));
      end
    end
  end

  // Keeps valid high across back-to-back beats; drops it only for a gap
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s);
    if ($urandom_range(99) < idle_pct) begin
      in_beat_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_beat_if.valid   <= 1'b1;
    in_beat_if.channel <= ch;
    in_beat_if.sample  <= s;
    @(posedge clk);
    while (!in_beat_if.ready) @(posedge clk);
    predict_sample(ch, s);
  endtask

  task automatic wait_idle();
    in_beat_if.valid <= 1'b0;
    @(posedge clk);
    while (stats_expected.size() != 0) @(posedge clk);
    // a non-closing beat may still be in the write-back stage
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [BS_W-1:0] bs);
    cfg_we    <= 1'b1;
    cfg_wdata <= bs;
    @(posedge clk);
    block_size_now = bs;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
    logic [SMP_W-1:0] near;
    near = rec_prev[ch] + SMP_W'($urandom_range(64)) - SMP_W'(32);
    case ($urandom_range(3))
      0: begin
        return near;
      end
      1: begin
        return $urandom_range(1) ? SAT16 : '0;
      end
      default: begin
        return SMP_W'($urandom);
      end
    endcase
  endfunction

  // Power-on block size of 16, extremes alternating so diff_sum saturates
  task automatic test_reset_block_size();
    for (int i = 0; i < 16; i++)
      send_sample(CH_W'(5), (i % 2) ? SAT16 : '0);
  endtask

  // Zero acts as one: every beat closes a single-sample block
  task automatic test_block_size_zero();
    wait_idle();
    write_block_size('0);
    send_sample(CH_W'(0), SAT16);
    send_sample(CH_W'(15), SMP_W'(1));
  endtask

  // Partial block of 255 cut short by lowering to 1; mean saturates
  task automatic test_block_size_lowered();
    wait_idle();
    write_block_size(BS_W'(255));
    repeat (3) send_sample(CH_W'(9), SAT16);
    send_sample(CH_W'(2), SMP_W'(16'h8001));
    wait_idle();
    write_block_size(BS_W'(1));
    send_sample(CH_W'(9), SAT16);
  endtask

  task automatic run_phase(input logic [BS_W-1:0] bs, input int idle, input int stall,
                           input int n, input int ch_lo, input int ch_hi);
    logic [CH_W-1:0] ch;
    wait_idle();
    write_block_size(bs);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) begin
      ch = CH_W'($urandom_range(ch_hi, ch_lo));
      send_sample(ch, pick_sample(ch));
    end
  endtask

  task automatic test_random_traffic();
    int one_ch;
    one_ch = $urandom_range(CHANNELS - 1);
    run_phase(BS_W'(4),   0,  0,  200, 0, CHANNELS - 1);
    run_phase(BS_W'(1),   83, 0,  100, 0, CHANNELS - 1);
    // full-size block needs a single busy channel to close within the phase
    run_phase(BS_W'(255), 0,  83, 270, one_ch, one_ch);
    run_phase(BS_W'(8),   38, 38, 200, 0, CHANNELS - 1);
    run_phase(BS_W'(2),   0,  83, 150, 0, CHANNELS - 1);
    run_phase(BS_W'(16),  83, 0,  200, 0, CHANNELS - 1);
    run_phase(BS_W'($urandom_range(12, 3)), 38, 38, 150, 0, CHANNELS - 1);
    run_phase('0,         0,  0,  80,  0, CHANNELS - 1);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_beat_if.valid   = 1'b0;
    in_beat_if.channel = '0;
    in_beat_if.sample  = '0;
    block_size_now     = BS_RESET;
    for (int i = 0; i < CHANNELS; i++) clear_record(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_block_size();
    test_block_size_zero();
    test_block_size_lowered();
    test_random_traffic();
    wait_idle();

    if (stats_expected.size() != 0) begin
      $display("%0d block results never arrived", stats_expected.size());
      mismatch_count += stats_expected.size();
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/adcbcs_pkg.sv
hdl/adcbcs_if.sv
hdl/adcbcs_ram.sv
hdl/adcbcs_update.sv
hdl/adcbcs_div.sv
hdl/adc_block_channel_stats.sv
tb/testbench.sv
